>>> hdl/gcc_pkg.sv
// Shared types and constants for the case/control genotype counter.
package gcc_pkg;

   localparam int CNT_W      = 17;
   localparam int SNP_W      = 24;
   localparam int IDX_W      = 16;
   localparam int CLASS_W    = 2;
   localparam int BYTE_W     = 8;
   localparam int PAIRS      = 4;
   localparam int PAIR_W     = 2;
   localparam int NUM_SLOTS  = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0] CNT_MAX        = {CNT_W{1'b1}};
   localparam logic [CNT_W-1:0] CFG_COUNT_INIT = CNT_W'(4);

   // request kinds
   localparam logic REQ_PHENO = 1'b0;
   localparam logic REQ_GENO  = 1'b1;

   // phenotype classes
   localparam logic [CLASS_W-1:0] PHEN_CASE    = 2'd0;
   localparam logic [CLASS_W-1:0] PHEN_MISSING = 2'd2;

   // genotype pair codes, {hi, lo}
   localparam logic [PAIR_W-1:0] GENO_MINOR = 2'b00;
   localparam logic [PAIR_W-1:0] GENO_MISS  = 2'b01;
   localparam logic [PAIR_W-1:0] GENO_HET   = 2'b10;
   localparam logic [PAIR_W-1:0] GENO_MAJOR = 2'b11;

   // slot offset within the case or control group
   localparam logic [1:0] OFF_MINOR = 2'd0;
   localparam logic [1:0] OFF_HET   = 2'd1;
   localparam logic [1:0] OFF_MAJOR = 2'd2;
   localparam logic [1:0] OFF_MISS  = 2'd3;

   // register word index
   localparam logic REG_COHORT_SIZE = 1'b0;

   typedef struct packed {
      logic                 req_type;
      logic [IDX_W-1:0]     person_index;
      logic [CLASS_W-1:0]   pheno_class;
      logic [BYTE_W-1:0]    geno_byte;
   } gcc_req_type;

   typedef struct packed {
      logic [SNP_W-1:0] snp_number;
      logic [CNT_W-1:0] case_minor_hom;
      logic [CNT_W-1:0] case_het;
      logic [CNT_W-1:0] case_major_hom;
      logic [CNT_W-1:0] case_missing;
      logic [CNT_W-1:0] ctrl_minor_hom;
      logic [CNT_W-1:0] ctrl_het;
      logic [CNT_W-1:0] ctrl_major_hom;
      logic [CNT_W-1:0] ctrl_missing;
   } gcc_rsp_type;

   // genotype byte after lookup issue, waiting for phenotype data
   typedef struct packed {
      logic               valid;
      logic               last;
      logic [PAIRS-1:0]   lane_en;
      logic [BYTE_W-1:0]  geno;
   } gcc_stage_type;

endpackage

>>> hdl/gcc_ram.sv
// Generic single-port-write RAM with registered read.
module gcc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 16384
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/gcc_csr.sv
// APB register block holding the individual count.
module gcc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [gcc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [gcc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [gcc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output logic [gcc_pkg::CNT_W-1:0]        cfg_count
);
   import gcc_pkg::*;

   logic             word_sel;
   logic             wr_hit;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign word_sel = csr_paddr[CSR_ADDR_W-1];
   assign wr_hit   = csr_psel && csr_penable && csr_pwrite && csr_pready
                     && (word_sel == REG_COHORT_SIZE);

   always_comb begin
      count_in = count_ff;
      if (wr_hit) begin
         count_in = csr_pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CFG_COUNT_INIT;
      end else begin
         count_ff <= count_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (word_sel == REG_COHORT_SIZE) ?
                       CSR_DATA_W'(count_ff) : '0;
   assign cfg_count  = count_ff;

endmodule

>>> hdl/gcc_tally.sv
// Genotype decode, saturating class counters and result register.
module gcc_tally (
   input  logic                                        clock,
   input  logic                                        reset,
   input  gcc_pkg::gcc_stage_type                      stage,
   input  logic [gcc_pkg::PAIRS*gcc_pkg::CLASS_W-1:0]  pheno_row,
   input  logic                                        rsp_stall,
   output logic                                        rsp_valid,
   output gcc_pkg::gcc_rsp_type                        rsp_data,
   output logic                                        stage_hold
);
   import gcc_pkg::*;

   logic [CNT_W-1:0]   cnt_ff  [NUM_SLOTS];
   logic [CNT_W-1:0]   cnt_in  [NUM_SLOTS];
   logic [CNT_W-1:0]   cnt_new [NUM_SLOTS];
   logic [PAIRS-1:0]   hit     [NUM_SLOTS];
   logic [2:0]         slot    [PAIRS];
   logic [PAIRS-1:0]   lane_on;
   logic [SNP_W-1:0]   snp_ff;
   logic [SNP_W-1:0]   snp_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   gcc_rsp_type        rsp_ff;
   gcc_rsp_type        rsp_in;
   logic               step;
   logic               emit;

   assign stage_hold = stage.valid && stage.last && rsp_valid_ff && rsp_stall;
   assign step       = stage.valid && !stage_hold;
   assign emit       = step && stage.last;

   // per-lane slot: {control, genotype offset}
   always_comb begin
      logic [CLASS_W-1:0] cls;
      logic [PAIR_W-1:0]  gt;
      logic [1:0]         off;
      for (int k = 0; k < PAIRS; k++) begin
         cls = pheno_row[k*CLASS_W +: CLASS_W];
         gt  = stage.geno[k*PAIR_W +: PAIR_W];
         unique case (gt)
            GENO_MINOR: off = OFF_MINOR;
            GENO_HET:   off = OFF_HET;
            GENO_MAJOR: off = OFF_MAJOR;
            GENO_MISS:  off = OFF_MISS;
            default:    off = OFF_MISS;
         endcase
         lane_on[k] = stage.lane_en[k] && (cls != PHEN_MISSING);
         slot[k]    = {(cls != PHEN_CASE), off};
      end
   end

   always_comb begin
      logic [2:0]       inc;
      logic [CNT_W:0]   sum;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         for (int k = 0; k < PAIRS; k++) begin
            hit[s][k] = lane_on[k] && (slot[k] == 3'(s));
         end
         inc = 3'($countones(hit[s]));
         sum = {1'b0, cnt_ff[s]} + (CNT_W+1)'(inc);
         cnt_new[s] = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
      end
   end

   always_comb begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
         cnt_in[s] = cnt_ff[s];
         if (emit) begin
            cnt_in[s] = '0;
         end else if (step) begin
            cnt_in[s] = cnt_new[s];
         end
      end
   end

   always_comb begin
      snp_in       = snp_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit) begin
         snp_in                = snp_ff + SNP_W'(1);
         rsp_valid_in          = 1'b1;
         rsp_in.snp_number     = snp_ff;
         rsp_in.case_minor_hom = cnt_new[0];
         rsp_in.case_het       = cnt_new[1];
         rsp_in.case_major_hom = cnt_new[2];
         rsp_in.case_missing   = cnt_new[3];
         rsp_in.ctrl_minor_hom = cnt_new[4];
         rsp_in.ctrl_het       = cnt_new[5];
         rsp_in.ctrl_major_hom = cnt_new[6];
         rsp_in.ctrl_missing   = cnt_new[7];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_SLOTS; s++) begin
            cnt_ff[s] <= '0;
         end
         snp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         snp_ff       <= snp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hdl/genotype_case_control_counter.sv
// A closing genotype byte goes to the stage register, then its counts to the rsp register.
// Throughput: one request per cycle; the phenotype RAM reads one row of four entries per byte.
// The input stalls only while a finished SNP waits behind an unread result.
// Reset: synchronous, clears counters, byte position, SNP number and individual count (to 4).
// Phenotype RAM is not cleared; entries must be written before genotype bytes use them.
module genotype_case_control_counter #(
   parameter int MAX_INDIVIDUALS = 65536
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  gcc_pkg::gcc_req_type             req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output gcc_pkg::gcc_rsp_type             rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [gcc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [gcc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [gcc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import gcc_pkg::*;

   localparam int ROWS   = (MAX_INDIVIDUALS + PAIRS - 1) / PAIRS;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int MAX_W  = $clog2(MAX_INDIVIDUALS + 1);
   localparam int N_W    = (MAX_W > CNT_W) ? MAX_W : CNT_W;
   localparam int CALC_W = ((N_W > ROW_W + 2) ? N_W : ROW_W + 2) + 1;

   logic [CNT_W-1:0]           cfg_count;
   logic [CALC_W-1:0]          n_eff;
   logic [CALC_W-1:0]          first;
   logic [CALC_W-1:0]          left;
   logic                       accept;
   logic                       geno_acc;
   logic                       pheno_acc;
   logic                       close_snp;
   logic [PAIRS-1:0]           lane_en;
   logic [ROW_W-1:0]           bpos_ff;
   logic [ROW_W-1:0]           bpos_in;
   logic [ROW_W-1:0]           wr_row;
   logic [PAIRS*CLASS_W-1:0]   pheno_row;
   gcc_stage_type              stage_ff;
   gcc_stage_type              stage_in;
   logic                       stage_hold;

   gcc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg_count   (cfg_count)
   );

   assign req_stall = stage_hold;
   assign accept    = req_valid && !req_stall;
   assign geno_acc  = accept && (req_data.req_type == REQ_GENO);
   assign pheno_acc = accept && (req_data.req_type == REQ_PHENO)
                      && (CALC_W'(req_data.person_index) < CALC_W'(MAX_INDIVIDUALS));
   assign wr_row    = ROW_W'(req_data.person_index >> 2);

   // count clamped to table size
   assign n_eff = (CALC_W'(cfg_count) > CALC_W'(MAX_INDIVIDUALS)) ?
                  CALC_W'(MAX_INDIVIDUALS) : CALC_W'(cfg_count);
   assign first = CALC_W'({bpos_ff, 2'b00});
   assign left  = n_eff - first;

   always_comb begin
      close_snp = 1'b1;
      lane_en   = '0;
      if (first < n_eff) begin
         if (left > CALC_W'(PAIRS)) begin
            close_snp = 1'b0;
            lane_en   = '1;
         end else begin
            unique case (left[2:0])
               3'd1:    lane_en = 4'b0001;
               3'd2:    lane_en = 4'b0011;
               3'd3:    lane_en = 4'b0111;
               default: lane_en = 4'b1111;
            endcase
         end
      end
   end

   always_comb begin
      bpos_in = bpos_ff;
      if (geno_acc) begin
         bpos_in = close_snp ? '0 : bpos_ff + ROW_W'(1);
      end
   end

   always_comb begin
      stage_in = stage_ff;
      if (!stage_hold) begin
         stage_in.valid   = geno_acc;
         stage_in.last    = close_snp;
         stage_in.lane_en = lane_en;
         stage_in.geno    = req_data.geno_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpos_ff  <= '0;
         stage_ff <= '0;
      end else begin
         bpos_ff  <= bpos_in;
         stage_ff <= stage_in;
      end
   end

   // one RAM lane per pair position within a byte
   for (genvar k = 0; k < PAIRS; k++) begin : g_lane
      gcc_ram #(
         .WIDTH (CLASS_W),
         .DEPTH (ROWS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (pheno_acc && (req_data.person_index[1:0] == 2'(k))),
         .wr_addr (wr_row),
         .wr_data (req_data.pheno_class),
         .rd_en   (geno_acc),
         .rd_addr (bpos_ff),
         .rd_data (pheno_row[k*CLASS_W +: CLASS_W])
      );
   end

   gcc_tally u_tally (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage_ff),
      .pheno_row  (pheno_row),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .stage_hold (stage_hold)
   );

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the case/control genotype counter: directed, random and stall runs.
`timescale 1ns / 100ps
module testbench;
   import gcc_pkg::*;

   localparam int TABLE_SIZE       = 65536;
   localparam int FILL_SIZE        = 512;
   localparam int RANDOM_PHASES    = 10;
   localparam int RANDOM_PER_PHASE = 90;
   localparam int TAIL_ITEMS       = 60;
   localparam int SETTLE_CYCLES    = 6;
   localparam int HOLD_CYCLES      = 300;
   localparam int CYCLE_LIMIT      = 1000000;
   localparam logic [CSR_ADDR_W-1:0] COUNT_ADDR = CSR_ADDR_W'({REG_COHORT_SIZE, 2'b00});

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   gcc_req_type           req_data;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   gcc_rsp_type           rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predictor state
   logic [CLASS_W-1:0] pheno_shadow [TABLE_SIZE];
   logic [CNT_W-1:0]   class_tally [NUM_SLOTS];
   int unsigned        byte_index;
   logic [SNP_W-1:0]   snp_index;
   logic [CNT_W-1:0]   individuals;
   gcc_rsp_type        snp_count_queue [$];

   int error_count = 0;
   int cycle_count = 0;
   int pheno_writes = 0;
   int geno_bytes = 0;
   int snps_checked = 0;
   int settings_applied = 0;
   bit tx_idle_on = 1'b1;
   bit rx_idle_on = 1'b1;
   int rx_hold_cycles = 0;
   int rx_burst_left = 0;

   genotype_case_control_counter #(.MAX_INDIVIDUALS(TABLE_SIZE)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d SNP results outstanding",
                  cycle_count, snp_count_queue.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("ERROR at %0t: %s", $time, what);
   endtask

   task automatic check_count(input string name, input logic [CNT_W-1:0] got,
                              input logic [CNT_W-1:0] want, input logic [SNP_W-1:0] snp);
      if (got !== want)
         report_mismatch($sformatf("snp %0d %s: got %0d, expected %0d", snp, name, got, want));
   endtask

   task automatic check_snp_counts(input gcc_rsp_type got);
      gcc_rsp_type want;
      if (snp_count_queue.size() == 0) begin
         report_mismatch($sformatf("unexpected result for snp %0d", got.snp_number));
         return;
      end
      want = snp_count_queue.pop_front();
      if (got.snp_number !== want.snp_number)
         report_mismatch($sformatf("snp_number: got %0d, expected %0d",
                                   got.snp_number, want.snp_number));
      check_count("case_minor_hom", got.case_minor_hom, want.case_minor_hom, want.snp_number);
      check_count("case_het", got.case_het, want.case_het, want.snp_number);
      check_count("case_major_hom", got.case_major_hom, want.case_major_hom, want.snp_number);
      check_count("case_missing", got.case_missing, want.case_missing, want.snp_number);
      check_count("ctrl_minor_hom", got.ctrl_minor_hom, want.ctrl_minor_hom, want.snp_number);
      check_count("ctrl_het", got.ctrl_het, want.ctrl_het, want.snp_number);
      check_count("ctrl_major_hom", got.ctrl_major_hom, want.ctrl_major_hom, want.snp_number);
      check_count("ctrl_missing", got.ctrl_missing, want.ctrl_missing, want.snp_number);
      snps_checked++;
   endtask

   // result side: check what is taken, then pick the next stall value
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_burst_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_snp_counts(rsp_data);
         if (rx_hold_cycles > 0) begin
            rx_hold_cycles--;
            rsp_stall <= 1'b1;
         end else if (rx_burst_left > 0) begin
            rx_burst_left--;
            rsp_stall <= 1'b1;
         end else if (rx_idle_on && $urandom_range(0, 11) == 0) begin
            rx_burst_left = $urandom_range(1, 18) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic count_genotype_byte(input logic [BYTE_W-1:0] geno);
      int unsigned n, first, left, pairs, k, slot;
      logic [CLASS_W-1:0] cls;
      logic [PAIR_W-1:0] code;
      bit last;
      gcc_rsp_type done;
      n = (individuals > TABLE_SIZE) ? TABLE_SIZE : individuals;
      first = byte_index * PAIRS;
      if (first >= n) begin
         // position already past the end: close the SNP with nothing counted
         pairs = 0;
         last = 1'b1;
      end else begin
         left = n - first;
         pairs = (left > PAIRS) ? PAIRS : left;
         last = (left <= PAIRS);
      end
      for (k = 0; k < pairs; k++) begin
         cls = pheno_shadow[first + k];
         code = {geno[2*k+1], geno[2*k]};
         if (cls != PHEN_MISSING) begin
            slot = (cls == PHEN_CASE) ? 0 : NUM_SLOTS / 2;
            case (code)
               GENO_MINOR: slot += OFF_MINOR;
               GENO_HET:   slot += OFF_HET;
               GENO_MAJOR: slot += OFF_MAJOR;
               default:    slot += OFF_MISS;
            endcase
            if (class_tally[slot] != CNT_MAX) class_tally[slot]++;
         end
      end
      if (!last) begin
         byte_index++;
      end else begin
         done.snp_number     = snp_index;
         done.case_minor_hom = class_tally[0];
         done.case_het       = class_tally[1];
         done.case_major_hom = class_tally[2];
         done.case_missing   = class_tally[3];
         done.ctrl_minor_hom = class_tally[4];
         done.ctrl_het       = class_tally[5];
         done.ctrl_major_hom = class_tally[6];
         done.ctrl_missing   = class_tally[7];
         snp_count_queue = {snp_count_queue, done};
         foreach (class_tally[s]) class_tally[s] = '0;
         byte_index = 0;
         snp_index++;
      end
   endtask

   // offer one request and hold it until the block takes it
   task automatic send_request(input gcc_req_type item);
      if (tx_idle_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (item.req_type == REQ_PHENO) begin
         pheno_shadow[item.person_index] = item.pheno_class;
         pheno_writes++;
      end else begin
         count_genotype_byte(item.geno_byte);
         geno_bytes++;
      end
   endtask

   task automatic send_pheno(input logic [IDX_W-1:0] idx, input logic [CLASS_W-1:0] cls);
      gcc_req_type item;
      item = '{req_type: REQ_PHENO, person_index: idx, pheno_class: cls,
               geno_byte: BYTE_W'($urandom)};
      send_request(item);
   endtask

   task automatic send_geno(input logic [BYTE_W-1:0] geno);
      gcc_req_type item;
      item = '{req_type: REQ_GENO, person_index: IDX_W'($urandom),
               pheno_class: CLASS_W'($urandom), geno_byte: geno};
      send_request(item);
   endtask

   // all results in, then a settling wait for a byte that closed nothing
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (snp_count_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_individuals(input logic [CSR_DATA_W-1:0] value);
      wait_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= COUNT_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[CNT_W-1:0] !== value[CNT_W-1:0])
         report_mismatch($sformatf("head count reads %0d, wrote %0d",
                                   csr_prdata[CNT_W-1:0], value[CNT_W-1:0]));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      individuals = value[CNT_W-1:0];
      settings_applied++;
   endtask

   task automatic test_directed();
      int i;
      for (i = 0; i < 8; i++) send_pheno(IDX_W'(i), CLASS_W'(i));
      // reset count of four: every byte is a whole SNP
      send_geno(8'h00);
      send_geno(8'hFF);
      send_geno(8'h55);
      send_geno(8'hAA);
      send_geno(8'hE4);
      send_pheno({IDX_W{1'b1}}, PHEN_MISSING);
      // partial last byte, upper pairs ignored
      set_individuals(1);
      send_geno(8'hFE);
      set_individuals(6);
      send_geno(8'h1B);
      send_geno(8'h0F);
      set_individuals(0);
      send_geno(8'hFF);
      // count lowered mid-SNP below the current position
      set_individuals(8);
      send_geno(8'hE4);
      set_individuals(2);
      send_geno(8'h00);
   endtask

   task automatic test_table_fill();
      int i;
      for (i = 0; i < FILL_SIZE; i++) send_pheno(IDX_W'(i), CLASS_W'($urandom_range(0, 3)));
   endtask

   task automatic test_random_stream();
      int phase, k;
      int unsigned count;
      logic [IDX_W-1:0] idx;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: count = 1;
            1: count = 3;
            2: count = 0;
            3: count = 5;
            4: count = FILL_SIZE;
            5: count = 4;
            6, 8: count = $urandom_range(1, 64);
            default: count = $urandom_range(65, FILL_SIZE);
         endcase
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on = ($urandom_range(0, 3) != 0);
         // phases rarely end on a SNP boundary, so this also changes the count mid-SNP
         set_individuals(count);
         for (k = 0; k < RANDOM_PER_PHASE; k++) begin
            if ($urandom_range(0, 7) == 0) begin
               idx = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom)
                                                 : IDX_W'($urandom_range(0, FILL_SIZE - 1));
               send_pheno(idx, CLASS_W'($urandom_range(0, 3)));
            end else begin
               send_geno(BYTE_W'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   task automatic test_backpressure();
      set_individuals(4);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      rx_hold_cycles = HOLD_CYCLES;
      repeat (60) send_geno(BYTE_W'($urandom_range(0, 255)));
      rx_idle_on = 1'b1;
   endtask

   // gap-free finish: a long SNP cut short by a smaller count, then short SNPs
   task automatic test_steady_tail();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      set_individuals(CSR_DATA_W'(FILL_SIZE));
      repeat (TAIL_ITEMS / 2) send_geno(BYTE_W'($urandom_range(0, 255)));
      set_individuals(CSR_DATA_W'(CFG_COUNT_INIT));
      repeat (TAIL_ITEMS / 2) send_geno(BYTE_W'($urandom_range(0, 255)));
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      foreach (class_tally[s]) class_tally[s] = '0;
      byte_index  = 0;
      snp_index   = '0;
      individuals = CFG_COUNT_INIT;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_table_fill();
      test_random_stream();
      test_backpressure();
      test_steady_tail();

      wait_idle();
      $display("Sent %0d phenotype writes and %0d genotype bytes over %0d count settings,",
               pheno_writes, geno_bytes, settings_applied);
      $display("with a long receiver hold and a gap-free finish; %0d SNP results compared.",
               snps_checked);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
